// ===== hw/rtl/rgbhsv_pkg.sv =====
package rgbhsv_pkg;

    // Field widths
    localparam int CHAN_W = 8;
    localparam int FRAC_W = 16;

    // Divider geometry: quotient bits resolved per pipeline stage
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES = FRAC_W / DIV_BITS_PER_STAGE;

    // Hue divisor is 6*delta, at most 1530
    localparam int HUE_DIV_W = 11;

    // Front end has two register stages ahead of the divider
    localparam int PREP_STAGES = 2;
    localparam int PIPE_LATENCY = PREP_STAGES + DIV_STAGES;

    // Word carried down the divider pipeline
    typedef struct packed {
        logic [HUE_DIV_W-1:0] hue_rem;
        logic [HUE_DIV_W-1:0] hue_div;
        logic [FRAC_W-1:0]    hue_q;
        logic                 hue_zero;
        logic [CHAN_W-1:0]    sat_rem;
        logic [FRAC_W-1:0]    sat_low;
        logic [CHAN_W-1:0]    sat_div;
        logic [FRAC_W-1:0]    sat_q;
        logic                 sat_zero;
        logic [CHAN_W-1:0]    value;
    } div_word_t;

endpackage

// ===== hw/rtl/rgbhsv_prep.sv =====
module rgbhsv_prep
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [7:0]               red,
    input  logic [7:0]               green,
    input  logic [7:0]               blue,
    output logic                     out_valid,
    output rgbhsv_pkg::div_word_t    out_word
);

    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    // Stage 1: max, min, sector and channel difference
    logic        s1_valid_reg;
    logic [7:0]  s1_max_reg, s1_max_next;
    logic [7:0]  s1_min_reg, s1_min_next;
    logic [1:0]  s1_sector_reg, s1_sector_next;
    logic [8:0]  s1_diff_reg, s1_diff_next;

    // Stage 2 registers
    logic                    s2_valid_reg;
    rgbhsv_pkg::div_word_t   s2_word_reg, s2_word_next;

    // Pick the largest channel; red wins ties, then green
    always_comb
    begin
        priority if (red >= green && red >= blue)
        begin
            s1_max_next    = red;
            s1_sector_next = SECT_RED;
            s1_diff_next   = {1'b0, green} - {1'b0, blue};
        end
        else if (green >= blue)
        begin
            s1_max_next    = green;
            s1_sector_next = SECT_GREEN;
            s1_diff_next   = {1'b0, blue} - {1'b0, red};
        end
        else
        begin
            s1_max_next    = blue;
            s1_sector_next = SECT_BLUE;
            s1_diff_next   = {1'b0, red} - {1'b0, green};
        end
    end

    // Smallest channel
    always_comb
    begin
        s1_min_next = (red < green) ? red : green;
        if (blue < s1_min_next)
        begin
            s1_min_next = blue;
        end
    end

    // Build hue numerator, divisors and the saturation dividend
    always_comb
    begin
        logic [7:0]  delta;
        logic [10:0] delta6;
        logic [10:0] base;
        logic [11:0] num;
        logic [23:0] sat_x;

        delta  = s1_max_reg - s1_min_reg;
        delta6 = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};

        unique case (s1_sector_reg)
            SECT_RED:   base = s1_diff_reg[8] ? delta6 : 11'd0;
            SECT_GREEN: base = {2'b00, delta, 1'b0};
            SECT_BLUE:  base = {1'b0, delta, 2'b00};
            default:    base = 11'd0;
        endcase

        num   = {1'b0, base} + {{3{s1_diff_reg[8]}}, s1_diff_reg};
        // delta*65535 = delta*65536 - delta
        sat_x = {delta, 16'h0000} - {16'h0000, delta};

        s2_word_next          = '0;
        s2_word_next.hue_rem  = num[10:0];
        s2_word_next.hue_div  = delta6;
        s2_word_next.hue_zero = (delta == 8'd0);
        s2_word_next.sat_rem  = sat_x[23:16];
        s2_word_next.sat_low  = sat_x[15:0];
        s2_word_next.sat_div  = s1_max_reg;
        s2_word_next.sat_zero = (s1_max_reg == 8'd0);
        s2_word_next.value    = s1_max_reg;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        s1_max_reg    <= s1_max_next;
        s1_min_reg    <= s1_min_next;
        s1_sector_reg <= s1_sector_next;
        s1_diff_reg   <= s1_diff_next;
        s2_word_reg   <= s2_word_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_word  = s2_word_reg;

endmodule

// ===== hw/rtl/rgbhsv_div_stage.sv =====
module rgbhsv_div_stage
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  rgbhsv_pkg::div_word_t    in_word,
    output logic                     out_valid,
    output rgbhsv_pkg::div_word_t    out_word
);

    logic                    valid_reg;
    rgbhsv_pkg::div_word_t   word_reg, word_next;

    // Resolve DIV_BITS_PER_STAGE quotient bits of both dividers by restoring steps
    always_comb
    begin
        logic [rgbhsv_pkg::HUE_DIV_W:0] hue_t;
        logic [rgbhsv_pkg::CHAN_W:0]    sat_t;
        logic                           hue_ge;
        logic                           sat_ge;

        word_next = in_word;
        for (int i = 0; i < rgbhsv_pkg::DIV_BITS_PER_STAGE; i++)
        begin
            hue_t  = {word_next.hue_rem, 1'b0};
            hue_ge = (hue_t >= {1'b0, word_next.hue_div});
            word_next.hue_rem = hue_ge ? hue_t[rgbhsv_pkg::HUE_DIV_W-1:0]
                                         - word_next.hue_div
                                       : hue_t[rgbhsv_pkg::HUE_DIV_W-1:0];
            word_next.hue_q = {word_next.hue_q[rgbhsv_pkg::FRAC_W-2:0],
                               hue_ge & ~word_next.hue_zero};

            sat_t  = {word_next.sat_rem, word_next.sat_low[rgbhsv_pkg::FRAC_W-1]};
            sat_ge = (sat_t >= {1'b0, word_next.sat_div});
            word_next.sat_rem = sat_ge ? sat_t[rgbhsv_pkg::CHAN_W-1:0]
                                         - word_next.sat_div
                                       : sat_t[rgbhsv_pkg::CHAN_W-1:0];
            word_next.sat_low = {word_next.sat_low[rgbhsv_pkg::FRAC_W-2:0], 1'b0};
            word_next.sat_q = {word_next.sat_q[rgbhsv_pkg::FRAC_W-2:0],
                               sat_ge & ~word_next.sat_zero};
        end
    end

    // Advance valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== hw/rtl/rgb_to_hsv_converter_core.sv =====
// Channel   Handshake          Fields
// -------   ----------------   -----------------------------------
// in        start / busy       red[7:0], green[7:0], blue[7:0]
// out       done (strobe)      hue[15:0], saturation[15:0], brightness[7:0]
//
// One pixel per clock, sustained; busy is always low.
// The pipeline has two front-end stages (max/min, then numerator and
// divisors) and eight divider stages, each resolving two quotient bits of
// the hue and saturation dividers side by side.
// Reset clears only the valid bits; payload registers are not reset.
// The receiver cannot stall, so the pipeline advances on every clock.
module rgb_to_hsv_converter_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        done,
    output logic [15:0] hue,
    output logic [15:0] saturation,
    output logic [7:0]  brightness
);

    logic                  stage_valid [rgbhsv_pkg::DIV_STAGES+1];
    rgbhsv_pkg::div_word_t stage_word  [rgbhsv_pkg::DIV_STAGES+1];

    // Front end: sector select, delta, divisors
    rgbhsv_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (stage_valid[0]),
        .out_word  (stage_word[0])
    );

    // Divider pipeline
    for (genvar s = 0; s < rgbhsv_pkg::DIV_STAGES; s++)
    begin : g_div
        rgbhsv_div_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[s]),
            .in_word   (stage_word[s]),
            .out_valid (stage_valid[s+1]),
            .out_word  (stage_word[s+1])
        );
    end

    assign busy       = 1'b0;
    assign done       = stage_valid[rgbhsv_pkg::DIV_STAGES];
    assign hue        = stage_word[rgbhsv_pkg::DIV_STAGES].hue_q;
    assign saturation = stage_word[rgbhsv_pkg::DIV_STAGES].sat_q;
    assign brightness = stage_word[rgbhsv_pkg::DIV_STAGES].value;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##10 done)
        else $error("accepted word did not emerge after pipeline latency");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && brightness == 8'd0) |-> (saturation == 16'd0 && hue == 16'd0))
        else $error("black pixel gave nonzero saturation or hue");

    a_hue_needs_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hue != 16'd0) |-> (saturation != 16'd0))
        else $error("nonzero hue with zero saturation");
`endif

endmodule
